FILE: rtl/bspm_pkg.sv
// Package for the blank and star pattern matcher.
// Holds sizes, register index codes, character codes and small helpers.
// No dependencies.
package bspm_pkg;

  // pattern store and counter sizes
  localparam int PATTERN_MAX     = 56;
  localparam int WORD_COUNT      = 7;
  localparam int WORD_WIDTH      = 64;
  localparam int POS_WIDTH       = 6;
  localparam int WORD_SEL_WIDTH  = 3;
  localparam int COUNT_WIDTH     = 16;
  localparam int OUT_WIDTH       = 16;
  localparam int CFG_INDEX_WIDTH = 4;

  // configuration register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_LENGTH     = 4'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_WORD_FIRST = 4'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_WORD_LAST  = 4'd7;

  // character codes
  localparam logic [7:0] CHAR_BLANK = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_STAR  = 8'h2A;

  // blank or tab
  function automatic logic is_space(input logic [7:0] c);
    return (c == CHAR_BLANK) || (c == CHAR_TAB);
  endfunction

endpackage

FILE: rtl/bspm_pattern_store.sv
// Pattern store: length register and seven pattern words, written over the
// configuration port, with a one-character lookup at the current position.
// Depends on bspm_pkg.
module bspm_pattern_store (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [bspm_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [bspm_pkg::WORD_WIDTH-1:0]      cfg_data,
  input  logic [bspm_pkg::POS_WIDTH-1:0]       position,
  output logic [bspm_pkg::POS_WIDTH-1:0]       length,
  output logic [7:0]                           pattern_char
);
  import bspm_pkg::*;

  logic [POS_WIDTH-1:0]  length_reg;
  logic [WORD_WIDTH-1:0] words [WORD_COUNT];
  logic [WORD_SEL_WIDTH-1:0] write_sel;
  logic [WORD_SEL_WIDTH-1:0] read_sel;
  logic [WORD_WIDTH-1:0]     read_word;

  assign write_sel = WORD_SEL_WIDTH'(cfg_index - REG_WORD_FIRST);

  // register writes, indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      length_reg <= '0;
      for (int i = 0; i < WORD_COUNT; i++) begin
        words[i] <= '0;
      end
    end else if (cfg_write) begin
      if (cfg_index == REG_LENGTH) begin
        length_reg <= cfg_data[POS_WIDTH-1:0];
      end else if (cfg_index >= REG_WORD_FIRST && cfg_index <= REG_WORD_LAST) begin
        words[write_sel] <= cfg_data;
      end
    end
  end

  // length clamped to the store size
  assign length = (length_reg > POS_WIDTH'(PATTERN_MAX)) ? POS_WIDTH'(PATTERN_MAX)
                                                         : length_reg;

  // word select wraps past the last word, then byte select
  assign read_sel  = (position[POS_WIDTH-1:3] >= WORD_SEL_WIDTH'(WORD_COUNT))
                     ? '0 : position[POS_WIDTH-1:3];
  assign read_word = words[read_sel];

  always_comb begin
    pattern_char = read_word[{position[2:0], 3'b000} +: 8];
  end

endmodule

FILE: rtl/blank_star_pattern_matcher.sv
// Top level of the blank and star pattern matcher: handshake, match sequencer
// and result register. Depends on bspm_pkg and bspm_pattern_store.
//
//   channel   direction  handshake           payload
//   config    in         cfg_write           cfg_index, cfg_data
//   subject   in         in_valid/in_ready   subject_char, end_of_text
//   result    out        out_valid/out_ready matched_count
//
// A character item is taken in S_IDLE and matched in S_RUN; a blank run that
// it opens is swept in S_SCAN over the remaining blanks and tabs, and each star
// it steps over starts a star skip that lasts until the pattern char matches;
// the sequencer does one match step a cycle on a single pattern lookup.
// The end-of-text item walks the remaining pattern the same way, then posts
// the result, and waits there while a previous result is held.
// Reset is synchronous and clears the pattern registers and match state.
// The next item is taken while a posted result still waits on out_ready.
module blank_star_pattern_matcher (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [bspm_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [bspm_pkg::WORD_WIDTH-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                           subject_char,
  input  logic                                end_of_text,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [bspm_pkg::OUT_WIDTH-1:0]       matched_count
);
  import bspm_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_SCAN} state_t;

  state_t state, state_next;
  logic [7:0] ch, ch_next;
  logic eot, eot_next;
  logic [POS_WIDTH-1:0] position, position_next;
  logic [COUNT_WIDTH-1:0] chars_consumed, chars_consumed_next;
  logic pattern_finished, pattern_finished_next;
  logic match_failed, match_failed_next;
  logic in_blank_run, in_blank_run_next;
  logic blank_seen, blank_seen_next;
  logic in_star_skip, in_star_skip_next;
  logic out_valid_reg, out_valid_next;
  logic [OUT_WIDTH-1:0] result, result_next;

  logic [POS_WIDTH-1:0] length;
  logic [7:0] pc;
  logic pos_end;
  logic [COUNT_WIDTH-1:0] count_inc;

  bspm_pattern_store u_store (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .position     (position),
    .length       (length),
    .pattern_char (pc)
  );

  assign pos_end   = position >= length;
  assign count_inc = (chars_consumed == '1) ? chars_consumed : chars_consumed + 1'b1;

  assign in_ready      = (state == S_IDLE);
  assign out_valid     = out_valid_reg;
  assign matched_count = result;

  // one match step per cycle
  always_comb begin
    state_next            = state;
    ch_next               = ch;
    eot_next              = eot;
    position_next         = position;
    chars_consumed_next   = chars_consumed;
    pattern_finished_next = pattern_finished;
    match_failed_next     = match_failed;
    in_blank_run_next     = in_blank_run;
    blank_seen_next       = blank_seen;
    in_star_skip_next     = in_star_skip;
    out_valid_next        = out_valid_reg && !out_ready;
    result_next           = result;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ch_next    = subject_char;
          eot_next   = end_of_text;
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        if (pattern_finished || match_failed) begin
          if (!eot) begin
            state_next = S_IDLE;
          end else if (!out_valid_reg || out_ready) begin
            // post the result and clear for the next text
            out_valid_next        = 1'b1;
            result_next           = (pattern_finished && !match_failed)
                                    ? OUT_WIDTH'(chars_consumed) : '0;
            position_next         = '0;
            chars_consumed_next   = '0;
            pattern_finished_next = 1'b0;
            match_failed_next     = 1'b0;
            in_blank_run_next     = 1'b0;
            blank_seen_next       = 1'b0;
            in_star_skip_next     = 1'b0;
            state_next            = S_IDLE;
          end
        end else if (in_star_skip) begin
          // skip until the next pattern character shows up
          if (!eot) begin
            if (pos_end || ch != pc) begin
              chars_consumed_next = count_inc;
              state_next          = S_IDLE;
            end else begin
              in_star_skip_next = 1'b0;
            end
          end else if (pos_end) begin
            pattern_finished_next = 1'b1;
          end else begin
            in_star_skip_next = 1'b0;
          end
        end else if (in_blank_run) begin
          if (!eot && is_space(ch)) begin
            chars_consumed_next = count_inc;
            blank_seen_next     = 1'b1;
            state_next          = S_IDLE;
          end else if (!blank_seen) begin
            match_failed_next = 1'b1;
            if (!eot) state_next = S_IDLE;
          end else begin
            in_blank_run_next = 1'b0;
          end
        end else if (pos_end) begin
          pattern_finished_next = 1'b1;
          if (!eot) state_next = S_IDLE;
        end else if (pc == CHAR_BLANK) begin
          // open a blank run, then sweep its remaining blanks and tabs
          blank_seen_next   = (position == '0);
          position_next     = position + 1'b1;
          in_blank_run_next = 1'b1;
          state_next        = S_SCAN;
        end else if (pc == CHAR_STAR) begin
          position_next     = position + 1'b1;
          in_star_skip_next = 1'b1;
        end else if (!eot && pc == ch) begin
          chars_consumed_next = count_inc;
          position_next       = position + 1'b1;
          state_next          = S_IDLE;
        end else begin
          match_failed_next = 1'b1;
          if (!eot) state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        if (!pos_end && is_space(pc)) begin
          position_next = position + 1'b1;
        end else begin
          state_next = S_RUN;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      position         <= '0;
      chars_consumed   <= '0;
      pattern_finished <= 1'b0;
      match_failed     <= 1'b0;
      in_blank_run     <= 1'b0;
      blank_seen       <= 1'b0;
      in_star_skip     <= 1'b0;
      out_valid_reg    <= 1'b0;
    end else begin
      state            <= state_next;
      position         <= position_next;
      chars_consumed   <= chars_consumed_next;
      pattern_finished <= pattern_finished_next;
      match_failed     <= match_failed_next;
      in_blank_run     <= in_blank_run_next;
      blank_seen       <= blank_seen_next;
      in_star_skip     <= in_star_skip_next;
      out_valid_reg    <= out_valid_next;
    end
    ch     <= ch_next;
    eot    <= eot_next;
    result <= result_next;
  end

endmodule

FILE: rtl/bspm_checker.sv
// Port-level checker for the blank and star pattern matcher, bound to the
// top level. Depends on bspm_pkg.
module bspm_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [bspm_pkg::OUT_WIDTH-1:0]       matched_count
);

  // a waiting result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(matched_count))
    else $error("result changed or dropped while stalled");

  // the sequencer is busy right after it takes an item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken on back-to-back cycles");

  // a new result is posted only from a busy sequencer
  a_result_from_run: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a pending item");

  // reset leaves no result pending
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind blank_star_pattern_matcher bspm_checker u_checker (.*);
